// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers, clocked on i_clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("assertion failed: invariant");

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/tlc_pkg.sv =====
package tlc_pkg;

    // Timing constants
    localparam int unsigned TICKS_PER_UNIT    = 1000;
    localparam int unsigned MAX_SECS          = 9;
    localparam int unsigned PERIODS_PER_PHASE = 4;

    localparam int unsigned GREEN_UNIT  = TICKS_PER_UNIT;
    localparam int unsigned YELLOW_UNIT = PERIODS_PER_PHASE * TICKS_PER_UNIT;

    // Field widths
    localparam int unsigned RATE_W  = 10;
    localparam int unsigned SECS_W  = 4;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned PER_W   = 3;
    localparam int unsigned PROD_W  = 20;

    // Lamp codes as seen on the light field
    localparam logic [1:0] LIGHT_GREEN  = 2'd0;
    localparam logic [1:0] LIGHT_YELLOW = 2'd1;
    localparam logic [1:0] LIGHT_RED    = 2'd2;

    // Edit targets
    localparam logic [1:0] TGT_GREEN  = 2'd0;
    localparam logic [1:0] TGT_YELLOW = 2'd1;
    localparam logic [1:0] TGT_RED    = 2'd2;
    localparam logic [1:0] TGT_MODE   = 2'd3;

    // Item kinds and button bits
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_BUTTON = 1'b1;
    localparam int unsigned BTN_UP  = 0;
    localparam int unsigned BTN_DN  = 1;
    localparam int unsigned BTN_SEL = 2;

    // Reciprocal of 60 scaled by 2**16; exact floor for any 10-bit rate
    localparam logic [10:0] RECIP60    = 11'd1093;
    localparam int unsigned RECIP_SHFT = 16;

    typedef enum logic [2:0] {
        LAMP_GREEN  = 3'b001,
        LAMP_YELLOW = 3'b010,
        LAMP_RED    = 3'b100
    } t_lamp;

    // Ticks for a duration, saturated to the counter width
    function automatic logic [TICK_W-1:0] sat_limit(input logic [SECS_W-1:0] secs,
                                                    input int unsigned unit);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(secs) * PROD_W'(unit);
        if (prod > PROD_W'({TICK_W{1'b1}})) begin
            return {TICK_W{1'b1}};
        end
        return prod[TICK_W-1:0];
    endfunction

    // Automatic green duration: rate / 60 + 1, capped at MAX_SECS
    function automatic logic [SECS_W-1:0] auto_green(input logic [RATE_W-1:0] rate);
        logic [RATE_W+10:0] prod;
        logic [SECS_W:0]    g;
        prod = (RATE_W+11)'(rate) * (RATE_W+11)'(RECIP60);
        g    = (SECS_W+1)'(prod >> RECIP_SHFT) + (SECS_W+1)'(1);
        if (g > (SECS_W+1)'(MAX_SECS)) begin
            g = (SECS_W+1)'(MAX_SECS);
        end
        return g[SECS_W-1:0];
    endfunction

    localparam logic [SECS_W-1:0] AUTO_GREEN_RST = SECS_W'(1);

endpackage

// ===== rtl/tlc_ifs.sv =====
// Item channel: one tick or button event per word.
interface tlc_item_if
    import tlc_pkg::*;
    ();
    logic       valid;
    logic       ready;
    logic       kind;
    logic [2:0] buttons;

    modport source (output valid, output kind, output buttons, input ready);
    modport sink   (input valid, input kind, input buttons, output ready);
endinterface

// Result channel: lamp and settings snapshot per word.
interface tlc_result_if
    import tlc_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [1:0]        light;
    logic              phase_pulse;
    logic              auto_mode;
    logic [1:0]        edit_target;
    logic [SECS_W-1:0] green_secs;
    logic [SECS_W-1:0] yellow_secs;
    logic [SECS_W-1:0] red_secs;

    modport source (output valid, output light, output phase_pulse, output auto_mode,
                    output edit_target, output green_secs, output yellow_secs,
                    output red_secs, input ready);
    modport sink   (input valid, input light, input phase_pulse, input auto_mode,
                    input edit_target, input green_secs, input yellow_secs,
                    input red_secs, output ready);
endinterface

// Configuration channel: car rate write word.
interface tlc_cfg_if
    import tlc_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] car_rate;

    modport source (output valid, output car_rate, input ready);
    modport sink   (input valid, input car_rate, output ready);
endinterface

// ===== rtl/traffic_light_controller.sv =====
// Traffic light sequencer with a four-target settings editor. Every accepted
// item word (a timer tick or a button event) produces exactly one result word,
// registered and held in an output register until taken. The block takes one
// item per clock: i_item.ready is high whenever the output register is empty
// or is being drained in the same cycle, so a stalled result holds off the
// input until it is taken. All per-item work (counter advance, period and phase
// end tests, editor step, limit recompute) is one combinational pass between the
// item handshake and the state/result registers; the critical path is the
// 16-bit tick increment and limit compare. The car rate write port is always
// ready; a write is turned into the automatic green duration at once and takes
// effect at the next button word. Durations are 1..9 units; green and red last
// four periods of their limit, yellow one period of four times its count.
`include "assert_macros.svh"

module traffic_light_controller
    import tlc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    tlc_item_if.sink     i_item,
    tlc_result_if.source o_result,
    tlc_cfg_if.sink      i_cfg
);

    // Sequencer state
    t_lamp             r_lamp, n_lamp;
    logic [TICK_W-1:0] r_tick_cnt, n_tick_cnt;
    logic [PER_W-1:0]  r_period_cnt, n_period_cnt;
    logic              n_pulse;

    // Editor state
    logic [1:0]        r_target, n_target;
    logic              r_auto, n_auto;
    logic [SECS_W-1:0] r_green_cnt, n_green_cnt;
    logic [SECS_W-1:0] r_yellow_cnt, n_yellow_cnt;
    logic [SECS_W-1:0] r_red_cnt, n_red_cnt;

    // Durations in use and their tick limits
    logic [SECS_W-1:0] r_green_secs, n_green_secs;
    logic [SECS_W-1:0] r_red_secs, n_red_secs;
    logic [TICK_W-1:0] r_green_lim, r_yellow_lim, r_red_lim;
    logic [TICK_W-1:0] n_green_lim, n_yellow_lim, n_red_lim;

    // Automatic green duration derived from the last car rate write
    logic [SECS_W-1:0] r_auto_green;

    // Result register
    logic              r_out_valid;
    logic [1:0]        r_out_light, n_light;
    logic              r_out_pulse;
    logic              r_out_auto;
    logic [1:0]        r_out_target;
    logic [SECS_W-1:0] r_out_green, r_out_yellow, r_out_red;

    logic              w_in_acc;
    logic              w_cfg_acc;

    // Step a count with up then down, each bounded to 1..MAX_SECS
    function automatic logic [SECS_W-1:0] edit_count(input logic [SECS_W-1:0] cnt,
                                                     input logic [2:0] btn);
        logic [SECS_W-1:0] c;
        c = cnt;
        if (btn[BTN_UP] && c < SECS_W'(MAX_SECS)) begin
            c = c + SECS_W'(1);
        end
        if (btn[BTN_DN] && c > SECS_W'(1)) begin
            c = c - SECS_W'(1);
        end
        return c;
    endfunction

    // Output slot is free, or frees up this cycle
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign w_in_acc     = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;
    assign w_cfg_acc    = i_cfg.valid;

    always_comb begin
        // Hold everything by default
        n_lamp       = r_lamp;
        n_tick_cnt   = r_tick_cnt;
        n_period_cnt = r_period_cnt;
        n_pulse      = 1'b0;
        n_target     = r_target;
        n_auto       = r_auto;
        n_green_cnt  = r_green_cnt;
        n_yellow_cnt = r_yellow_cnt;
        n_red_cnt    = r_red_cnt;
        n_green_secs = r_green_secs;
        n_red_secs   = r_red_secs;

        if (i_item.kind == KIND_TICK) begin
            // Advance the counter, then test the end of the current lamp's period.
            // A period end clears the counter, so at most one end per tick.
            n_tick_cnt = r_tick_cnt + TICK_W'(1);
            unique case (r_lamp)
                LAMP_GREEN: begin
                    if (n_tick_cnt >= r_green_lim) begin
                        n_pulse      = 1'b1;
                        n_tick_cnt   = '0;
                        n_period_cnt = r_period_cnt + PER_W'(1);
                        if (n_period_cnt >= PER_W'(PERIODS_PER_PHASE)) begin
                            n_lamp       = LAMP_YELLOW;
                            n_period_cnt = '0;
                        end
                    end
                end
                LAMP_YELLOW: begin
                    if (n_tick_cnt >= r_yellow_lim) begin
                        n_pulse    = 1'b1;
                        n_tick_cnt = '0;
                        n_lamp     = LAMP_RED;
                    end
                end
                LAMP_RED: begin
                    if (n_tick_cnt >= r_red_lim) begin
                        n_pulse      = 1'b1;
                        n_tick_cnt   = '0;
                        n_period_cnt = r_period_cnt + PER_W'(1);
                        if (n_period_cnt >= PER_W'(PERIODS_PER_PHASE)) begin
                            n_lamp       = LAMP_GREEN;
                            n_period_cnt = '0;
                        end
                    end
                end
                default: begin
                    n_lamp = r_lamp;
                end
            endcase
        end else begin
            // Manual editing: select moves the target first, then up/down edit it
            if (!r_auto) begin
                if (i_item.buttons[BTN_SEL]) begin
                    n_target = r_target + 2'd1;
                end
                unique case (n_target)
                    TGT_GREEN:  n_green_cnt  = edit_count(r_green_cnt, i_item.buttons);
                    TGT_YELLOW: n_yellow_cnt = edit_count(r_yellow_cnt, i_item.buttons);
                    TGT_RED:    n_red_cnt    = edit_count(r_red_cnt, i_item.buttons);
                    default:    n_red_cnt    = r_red_cnt;
                endcase
            end
            // Mode target: either button toggles, in either mode
            if (n_target == TGT_MODE && (i_item.buttons[BTN_UP] || i_item.buttons[BTN_DN])) begin
                n_auto = !r_auto;
            end
            // Recompute the durations in use
            if (n_auto) begin
                n_green_secs = r_auto_green;
                n_red_secs   = SECS_W'(MAX_SECS + 1) - r_auto_green;
            end else begin
                n_green_secs = n_green_cnt;
                n_red_secs   = n_red_cnt;
            end
        end
    end

    assign n_green_lim  = sat_limit(n_green_secs, GREEN_UNIT);
    assign n_red_lim    = sat_limit(n_red_secs, GREEN_UNIT);
    assign n_yellow_lim = sat_limit(n_yellow_cnt, YELLOW_UNIT);

    always_comb begin
        unique case (n_lamp)
            LAMP_GREEN:  n_light = LIGHT_GREEN;
            LAMP_YELLOW: n_light = LIGHT_YELLOW;
            default:     n_light = LIGHT_RED;
        endcase
    end

    // State advances only on an accepted item word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp       <= LAMP_GREEN;
            r_tick_cnt   <= '0;
            r_period_cnt <= '0;
            r_target     <= TGT_GREEN;
            r_auto       <= 1'b0;
            r_green_cnt  <= SECS_W'(1);
            r_yellow_cnt <= SECS_W'(1);
            r_red_cnt    <= SECS_W'(1);
            r_green_secs <= SECS_W'(1);
            r_red_secs   <= SECS_W'(1);
            r_green_lim  <= sat_limit(SECS_W'(1), GREEN_UNIT);
            r_red_lim    <= sat_limit(SECS_W'(1), GREEN_UNIT);
            r_yellow_lim <= sat_limit(SECS_W'(1), YELLOW_UNIT);
        end else if (w_in_acc) begin
            r_lamp       <= n_lamp;
            r_tick_cnt   <= n_tick_cnt;
            r_period_cnt <= n_period_cnt;
            r_target     <= n_target;
            r_auto       <= n_auto;
            r_green_cnt  <= n_green_cnt;
            r_yellow_cnt <= n_yellow_cnt;
            r_red_cnt    <= n_red_cnt;
            r_green_secs <= n_green_secs;
            r_red_secs   <= n_red_secs;
            r_green_lim  <= n_green_lim;
            r_red_lim    <= n_red_lim;
            r_yellow_lim <= n_yellow_lim;
        end
    end

    // Convert the car rate on write; only the derived duration is kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_green <= AUTO_GREEN_RST;
        end else if (w_cfg_acc) begin
            r_auto_green <= auto_green(i_cfg.car_rate);
        end
    end

    // Result register: load on accept, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_in_acc || (r_out_valid && !o_result.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_light  <= n_light;
            r_out_pulse  <= n_pulse;
            r_out_auto   <= n_auto;
            r_out_target <= n_target;
            r_out_green  <= n_green_secs;
            r_out_yellow <= n_yellow_cnt;
            r_out_red    <= n_red_secs;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.light       = r_out_light;
    assign o_result.phase_pulse = r_out_pulse;
    assign o_result.auto_mode   = r_out_auto;
    assign o_result.edit_target = r_out_target;
    assign o_result.green_secs  = r_out_green;
    assign o_result.yellow_secs = r_out_yellow;
    assign o_result.red_secs    = r_out_red;

    // Period count never reaches the phase length
    `ASSERT_HOLDS(a_period_bound, r_period_cnt < PER_W'(PERIODS_PER_PHASE))

    // Edited counts stay within 1..MAX_SECS
    `ASSERT_HOLDS(a_green_cnt_range,
        r_green_cnt >= SECS_W'(1) && r_green_cnt <= SECS_W'(MAX_SECS))

    // Automatic green and red always split MAX_SECS + 1
    `ASSERT_IMPLIES(a_auto_split, r_auto,
        (SECS_W+1)'(r_green_secs) + (SECS_W+1)'(r_red_secs) == (SECS_W+1)'(MAX_SECS + 1))

    // Button words never move the lamp
    `ASSERT_NEXT(a_button_keeps_lamp, w_in_acc && i_item.kind == KIND_BUTTON,
        $stable(r_lamp))

endmodule
